// ----- hdl/rgbs_pkg.sv -----
`timescale 1ns / 1ps
// Types, constants and arithmetic helpers of the running Gaussian background subtractor.
// No dependencies; used by every module of the block.
package rgbs_pkg;

    localparam int unsigned PIXELS     = 307200;
    localparam int unsigned PTR_W      = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int unsigned CNT_W      = $clog2(PIXELS + 1);
    localparam int unsigned FRAMES_MAX = 1023;
    localparam int unsigned CMDQ_DEPTH = 4;
    localparam int unsigned CMDQ_AW    = $clog2(CMDQ_DEPTH);
    localparam int unsigned OUTQ_DEPTH = 32;
    localparam int unsigned OUTQ_AW    = $clog2(OUTQ_DEPTH);
    localparam int unsigned NSTAGE     = 18;
    localparam int unsigned WB_STAGE   = 15;
    localparam int unsigned SQ_STAGES  = 9;
    localparam int unsigned CFG_W      = 19;
    localparam int unsigned CFG_AW     = 3;

    typedef enum logic [CFG_AW-1:0] {
        REG_ALPHA       = 3'd0,
        REG_LEARN_ALPHA = 3'd1,
        REG_SPREAD_K    = 3'd2,
        REG_LEARN_FRMS  = 3'd3,
        REG_MOTION_THR  = 3'd4,
        REG_INIT_SPREAD = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic       req_type;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_end;
    } in_t;

    typedef struct packed {
        logic foreground;
        logic learning;
        logic motion;
        logic last;
    } out_t;

    typedef struct packed {
        logic [15:0] alpha;
        logic [15:0] learn_alpha;
        logic [11:0] spread_factor;
        logic [9:0]  learn_frames;
        logic [18:0] motion_pixel_threshold;
        logic [15:0] initial_spread;
    } cfg_t;

    typedef struct packed {
        logic             is_proc;
        logic [2:0][7:0]  px;
        logic             fend;
        logic             learning;
        logic             motion_ok;
        logic [15:0]      a;
        logic [PTR_W-1:0] idx;
    } cmd_t;

    typedef struct packed {
        logic [19:0] rem;
        logic [17:0] root;
    } sq_t;

    function automatic sq_t sqrt_step(input sq_t s, input logic [1:0] b);
        logic [21:0] rem_sh;
        logic [21:0] trial;
        sq_t         r;
        rem_sh = {s.rem, b};
        trial  = {2'b00, s.root, 2'b01};
        if (rem_sh >= trial)
        begin
            r.rem  = 20'(rem_sh - trial);
            r.root = {s.root[16:0], 1'b1};
        end
        else
        begin
            r.rem  = rem_sh[19:0];
            r.root = {s.root[16:0], 1'b0};
        end
        return r;
    endfunction

endpackage

// ----- hdl/rgbs_front.sv -----
`timescale 1ns / 1ps
// Front part: accepts pixels, keeps pixel pointer and frame count, classifies each item.
// Depends on rgbs_pkg.
module rgbs_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  rgbs_pkg::in_t  item,
    input  rgbs_pkg::cfg_t cfg,
    input  logic           q_full,
    output logic           cmd_push,
    output rgbs_pkg::cmd_t cmd
);
    import rgbs_pkg::*;

    logic [PTR_W-1:0] ptr_reg, ptr_next;
    logic [9:0]       frames_reg, frames_next;
    logic             learning;

    assign cmd_push = push & ~q_full;
    assign learning = frames_reg < cfg.learn_frames;

    always_comb
    begin
        cmd.is_proc   = item.req_type;
        cmd.px        = {item.blue, item.green, item.red};
        cmd.fend      = item.frame_end;
        cmd.learning  = learning;
        cmd.motion_ok = frames_reg > cfg.learn_frames;
        cmd.a         = learning ? cfg.learn_alpha : cfg.alpha;
        cmd.idx       = ptr_reg;

        frames_next = frames_reg;
        if (item.req_type && item.frame_end && frames_reg < 10'(FRAMES_MAX))
            frames_next = frames_reg + 10'd1;

        if (item.frame_end || ptr_reg == PTR_W'(PIXELS - 1))
            ptr_next = '0;
        else
            ptr_next = ptr_reg + PTR_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg    <= '0;
            frames_reg <= '0;
        end
        else if (cmd_push)
        begin
            ptr_reg    <= ptr_next;
            frames_reg <= frames_next;
        end
    end

endmodule

// ----- hdl/rgbs_cmdq.sv -----
`timescale 1ns / 1ps
// Short command queue between the front and back parts.
// Depends on rgbs_pkg.
module rgbs_cmdq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr,
    input  rgbs_pkg::cmd_t wdata,
    input  logic           rd,
    output rgbs_pkg::cmd_t head,
    output logic           q_empty,
    output logic           q_full
);
    import rgbs_pkg::*;

    cmd_t               mem_reg [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0] wp_reg, rp_reg;
    logic [CMDQ_AW:0]   cnt_reg;

    assign head    = mem_reg[rp_reg];
    assign q_empty = cnt_reg == '0;
    assign q_full  = cnt_reg == (CMDQ_AW+1)'(CMDQ_DEPTH);

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
                wp_reg <= wp_reg + CMDQ_AW'(1);
            if (rd)
                rp_reg <= rp_reg + CMDQ_AW'(1);
            cnt_reg <= cnt_reg + (CMDQ_AW+1)'(wr) - (CMDQ_AW+1)'(rd);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) wr |-> !q_full || rd)
        else $error("command queue overflow");
    assert property (@(posedge clk) disable iff (!rst_n) rd |-> !q_empty)
        else $error("command queue underflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (wr && !rd) |=> cnt_reg == $past(cnt_reg) + (CMDQ_AW+1)'(1))
        else $error("command queue count slip");

endmodule

// ----- hdl/rgbs_back.sv -----
`timescale 1ns / 1ps
// Back part: pixel state memory, mean/spread update pipeline, foreground test, result queue.
// Depends on rgbs_pkg.
module rgbs_back (
    input  logic           clk,
    input  logic           rst_n,
    input  rgbs_pkg::cfg_t cfg,
    input  rgbs_pkg::cmd_t head,
    input  logic           q_empty,
    output logic           issue,
    output logic           empty,
    input  logic           pop,
    output rgbs_pkg::out_t result
);
    import rgbs_pkg::*;

    typedef struct packed {
        cmd_t             cmd;
        logic [2:0][15:0] nm;
        logic [48:0]      nass;
        logic [33:0]      d2;
    } pipe_t;

    logic [63:0]       ram [PIXELS];
    logic [63:0]       rd_reg;

    logic              vld_reg  [NSTAGE];
    pipe_t             pipe_reg [NSTAGE];
    pipe_t             pipe_next[NSTAGE];

    logic [31:0]       pa_reg [3], pa_next [3];
    logic [32:0]       pm_reg [3], pm_next [3];
    logic [31:0]       ss_reg, ss_next;
    logic [15:0]       diff_reg [3], diff_next [3];
    logic [31:0]       sq_reg [3], sq_next [3];
    logic [49:0]       ad_reg, ad_next;
    logic [35:0]       v_reg  [SQ_STAGES+1];
    sq_t               st_reg [SQ_STAGES+1];
    logic [35:0]       v_next [SQ_STAGES+1];
    sq_t               st_next[SQ_STAGES+1];
    logic [27:0]       ks_reg, ks_next;
    logic [55:0]       kss_reg, kss_next;

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [OUTQ_AW:0]  occ_reg;
    out_t              oq_reg [OUTQ_DEPTH];
    logic [OUTQ_AW-1:0] owp_reg, orp_reg;
    logic [OUTQ_AW:0]  ocnt_reg;

    logic              hazard;
    logic              opush;
    logic              opop;
    out_t              res_new;
    logic [15:0]       ns;
    logic [63:0]       wdata;
    logic [16:0]       na1, na2;
    logic [33:0]       nm_sum [3];
    logic [50:0]       var_sum;
    logic              fg;

    always_comb
    begin
        hazard = 1'b0;
        for (int k = 0; k <= WB_STAGE; k++)
            if (vld_reg[k] && pipe_reg[k].cmd.idx == head.idx)
                hazard = 1'b1;
    end

    assign issue = !q_empty && !hazard && (occ_reg < (OUTQ_AW+1)'(OUTQ_DEPTH));
    assign opush = vld_reg[NSTAGE-1];
    assign opop  = pop && !empty;

    always_comb
    begin
        for (int k = 0; k < NSTAGE; k++)
            pipe_next[k] = (k == 0) ? pipe_reg[0] : pipe_reg[k-1];
        pipe_next[0].cmd = head;

        na1 = 17'h10000 - 17'(pipe_reg[0].cmd.a);
        for (int c = 0; c < 3; c++)
        begin
            pa_next[c] = 32'(pipe_reg[0].cmd.a) * 32'({pipe_reg[0].cmd.px[c], 8'h00});
            pm_next[c] = 33'(na1) * 33'(rd_reg[16*c +: 16]);
        end
        ss_next = 32'(rd_reg[63:48]) * 32'(rd_reg[63:48]);

        na2 = 17'h10000 - 17'(pipe_reg[1].cmd.a);
        for (int c = 0; c < 3; c++)
        begin
            nm_sum[c] = 34'(pa_reg[c]) + 34'(pm_reg[c]) + 34'd32768;
            pipe_next[2].nm[c] = nm_sum[c][31:16];
            diff_next[c] = (nm_sum[c][31:16] > {pipe_reg[1].cmd.px[c], 8'h00})
                ? nm_sum[c][31:16] - {pipe_reg[1].cmd.px[c], 8'h00}
                : {pipe_reg[1].cmd.px[c], 8'h00} - nm_sum[c][31:16];
        end
        pipe_next[2].nass = 49'(na2) * 49'(ss_reg);

        for (int c = 0; c < 3; c++)
            sq_next[c] = 32'(diff_reg[c]) * 32'(diff_reg[c]);

        pipe_next[4].d2 = 34'(sq_reg[0]) + 34'(sq_reg[1]) + 34'(sq_reg[2]);

        ad_next = 50'(pipe_reg[4].cmd.a) * 50'(pipe_reg[4].d2);

        var_sum   = 51'(ad_reg) + 51'(pipe_reg[5].nass) + 51'd32768;
        v_next[0] = {1'b0, var_sum[50:16]};
        st_next[0] = '0;
        for (int j = 0; j < SQ_STAGES; j++)
        begin
            st_next[j+1] = sqrt_step(sqrt_step(st_reg[j], v_reg[j][35:34]),
                                     v_reg[j][33:32]);
            v_next[j+1]  = {v_reg[j][31:0], 4'h0};
        end

        ns = (st_reg[SQ_STAGES].root > 18'h0FFFF) ? 16'hFFFF
                                                   : st_reg[SQ_STAGES].root[15:0];
        if (pipe_reg[WB_STAGE].cmd.is_proc)
            wdata = {ns, pipe_reg[WB_STAGE].nm[2], pipe_reg[WB_STAGE].nm[1],
                     pipe_reg[WB_STAGE].nm[0]};
        else
            wdata = {cfg.initial_spread,
                     pipe_reg[WB_STAGE].cmd.px[2], 8'h00,
                     pipe_reg[WB_STAGE].cmd.px[1], 8'h00,
                     pipe_reg[WB_STAGE].cmd.px[0], 8'h00};
        ks_next  = 28'(cfg.spread_factor) * 28'(ns);
        kss_next = 56'(ks_reg) * 56'(ks_reg);
    end

    always_comb
    begin
        fg = pipe_reg[NSTAGE-1].cmd.is_proc && !pipe_reg[NSTAGE-1].cmd.learning
             && (56'({pipe_reg[NSTAGE-1].d2, 16'h0000}) > kss_reg);
        cnt_next = cnt_reg;
        if (fg && cnt_reg < CNT_W'(PIXELS))
            cnt_next = cnt_reg + CNT_W'(1);
        res_new.foreground = fg;
        res_new.learning   = pipe_reg[NSTAGE-1].cmd.learning;
        res_new.motion     = pipe_reg[NSTAGE-1].cmd.is_proc && pipe_reg[NSTAGE-1].cmd.fend
                             && pipe_reg[NSTAGE-1].cmd.motion_ok
                             && (32'(cnt_next) > 32'(cfg.motion_pixel_threshold));
        res_new.last       = pipe_reg[NSTAGE-1].cmd.fend;
    end

    always_ff @(posedge clk)
    begin
        if (issue)
            rd_reg <= ram[head.idx];
        if (vld_reg[WB_STAGE])
            ram[pipe_reg[WB_STAGE].cmd.idx] <= wdata;
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NSTAGE; k++)
            pipe_reg[k] <= pipe_next[k];
        for (int c = 0; c < 3; c++)
        begin
            pa_reg[c]   <= pa_next[c];
            pm_reg[c]   <= pm_next[c];
            diff_reg[c] <= diff_next[c];
            sq_reg[c]   <= sq_next[c];
        end
        ss_reg <= ss_next;
        ad_reg <= ad_next;
        for (int j = 0; j <= SQ_STAGES; j++)
        begin
            v_reg[j]  <= v_next[j];
            st_reg[j] <= st_next[j];
        end
        ks_reg  <= ks_next;
        kss_reg <= kss_next;
        if (opush)
            oq_reg[owp_reg] <= res_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NSTAGE; k++)
                vld_reg[k] <= 1'b0;
            cnt_reg  <= '0;
            occ_reg  <= '0;
            owp_reg  <= '0;
            orp_reg  <= '0;
            ocnt_reg <= '0;
        end
        else
        begin
            vld_reg[0] <= issue;
            for (int k = 1; k < NSTAGE; k++)
                vld_reg[k] <= vld_reg[k-1];
            if (opush)
                cnt_reg <= pipe_reg[NSTAGE-1].cmd.fend ? '0 : cnt_next;
            occ_reg <= occ_reg + (OUTQ_AW+1)'(issue) - (OUTQ_AW+1)'(opop);
            if (opush)
                owp_reg <= owp_reg + OUTQ_AW'(1);
            if (opop)
                orp_reg <= orp_reg + OUTQ_AW'(1);
            ocnt_reg <= ocnt_reg + (OUTQ_AW+1)'(opush) - (OUTQ_AW+1)'(opop);
        end
    end

    assign empty  = ocnt_reg == '0;
    assign result = oq_reg[orp_reg];

    assert property (@(posedge clk) disable iff (!rst_n)
        opush |-> ocnt_reg < (OUTQ_AW+1)'(OUTQ_DEPTH) || opop)
        else $error("result queue overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= (OUTQ_AW+1)'(OUTQ_DEPTH) && occ_reg >= ocnt_reg)
        else $error("in-flight credit out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        (opush && pipe_reg[NSTAGE-1].cmd.fend) |=> cnt_reg == '0)
        else $error("foreground count not cleared at frame end");
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(PIXELS))
        else $error("foreground count beyond pixel count");

endmodule

// ----- hdl/running_gaussian_background_subtractor_top.sv -----
// Running Gaussian background subtractor, top level.
// Throughput: one pixel per cycle while the result queue has room; a pixel whose
// state is still in the 16-stage read-to-writeback window of the update pipeline
// waits until it is written back.
// Reset clears pointer, frame and foreground counts and loads register defaults;
// the pixel memory is not cleared and must be seeded by load items.
`timescale 1ns / 1ps
module running_gaussian_background_subtractor_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  rgbs_pkg::in_t                   item,
    output logic                            empty,
    input  logic                            pop,
    output rgbs_pkg::out_t                  result,
    input  logic                            cfg_we,
    input  logic [rgbs_pkg::CFG_AW-1:0]     cfg_addr,
    input  logic [rgbs_pkg::CFG_W-1:0]      cfg_wdata
);
    import rgbs_pkg::*;

    cfg_t cfg_reg;
    cmd_t cmd, head;
    logic cmd_push, issue, q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alpha                  <= 16'd655;
            cfg_reg.learn_alpha            <= 16'd3277;
            cfg_reg.spread_factor          <= 12'd768;
            cfg_reg.learn_frames           <= 10'd10;
            cfg_reg.motion_pixel_threshold <= 19'd1024;
            cfg_reg.initial_spread         <= 16'd512;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_ALPHA:       cfg_reg.alpha                  <= cfg_wdata[15:0];
                REG_LEARN_ALPHA: cfg_reg.learn_alpha            <= cfg_wdata[15:0];
                REG_SPREAD_K:    cfg_reg.spread_factor          <= cfg_wdata[11:0];
                REG_LEARN_FRMS:  cfg_reg.learn_frames           <= cfg_wdata[9:0];
                REG_MOTION_THR:  cfg_reg.motion_pixel_threshold <= cfg_wdata[18:0];
                REG_INIT_SPREAD: cfg_reg.initial_spread         <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    rgbs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item     (item),
        .cfg      (cfg_reg),
        .q_full   (full),
        .cmd_push (cmd_push),
        .cmd      (cmd)
    );

    rgbs_cmdq u_cmdq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (cmd_push),
        .wdata   (cmd),
        .rd      (issue),
        .head    (head),
        .q_empty (q_empty),
        .q_full  (full)
    );

    rgbs_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .head    (head),
        .q_empty (q_empty),
        .issue   (issue),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule
